[hdl/sle_pkg.sv]
package sle_pkg;

    localparam int CMD_W     = 2;
    localparam int POS_W     = 9;
    localparam int VAL_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int IDX_W     = 8;
    localparam int COUNT_W   = 9;

    localparam int IN_CMD_LSB = 0;
    localparam int IN_POS_LSB = IN_CMD_LSB + CMD_W;
    localparam int IN_VAL_LSB = IN_POS_LSB + POS_W;
    localparam int IN_BITS    = IN_VAL_LSB + VAL_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_IDX_LSB    = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_COUNT_LSB  = OUT_IDX_LSB + IDX_W;
    localparam int OUT_BITS       = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_MODIFY = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PTR_HOLD    = 3'd0,
        PTR_LOAD_UP = 3'd1,
        PTR_LOAD_DN = 3'd2,
        PTR_ZERO    = 3'd3,
        PTR_INC     = 3'd4,
        PTR_DEC     = 3'd5
    } t_ptr_op;

    typedef enum logic [1:0] {
        WB_NONE = 2'd0,
        WB_UP   = 2'd1,
        WB_DN   = 2'd2,
        WB_VAL  = 2'd3
    } t_wb_op;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } t_cnt_op;

    typedef struct packed {
        logic    load;
        logic    rd;
        t_ptr_op ptr_op;
        t_wb_op  wb_op;
        t_cnt_op cnt_op;
        logic    res_set;
        t_status res_status;
        logic    res_idx_prev;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic pos_gt;
        logic pos_eq;
        logic pos_last;
        logic full;
        logic cnt_zero;
        logic ptr_at_pos;
        logic ptr_at_last;
        logic hit;
        logic out_free;
    } t_dp_sts;

endpackage

[hdl/sle_ram.sv]
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[hdl/sle_ctrl.sv]
module sle_ctrl
    import sle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_DISPATCH  = 10'b00_0000_0010,
        S_SHIFT_UP  = 10'b00_0000_0100,
        S_UP_TAIL   = 10'b00_0000_1000,
        S_WR_VAL    = 10'b00_0001_0000,
        S_SHIFT_DN  = 10'b00_0010_0000,
        S_DN_TAIL   = 10'b00_0100_0000,
        S_SCAN      = 10'b00_1000_0000,
        S_SCAN_TAIL = 10'b01_0000_0000,
        S_RESP      = 10'b10_0000_0000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd c;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cmd      = c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        c.load           = 1'b0;
        c.rd             = 1'b0;
        c.ptr_op         = PTR_HOLD;
        c.wb_op          = WB_NONE;
        c.cnt_op         = CNT_HOLD;
        c.res_set        = 1'b0;
        c.res_status     = ST_OK;
        c.res_idx_prev   = 1'b0;
        c.emit           = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    c.load  = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.cmd)
                    CMD_INSERT: begin
                        if (i_sts.pos_gt) begin
                            c.res_set    = 1'b1;
                            c.res_status = ST_RANGE;
                            n_state      = S_RESP;
                        end else if (i_sts.full) begin
                            c.res_set    = 1'b1;
                            c.res_status = ST_FULL;
                            n_state      = S_RESP;
                        end else if (i_sts.pos_eq) begin
                            n_state = S_WR_VAL;
                        end else begin
                            c.ptr_op = PTR_LOAD_UP;
                            n_state  = S_SHIFT_UP;
                        end
                    end
                    CMD_ERASE: begin
                        if (i_sts.pos_gt || i_sts.pos_eq) begin
                            c.res_set    = 1'b1;
                            c.res_status = ST_RANGE;
                            n_state      = S_RESP;
                        end else if (i_sts.pos_last) begin
                            c.cnt_op     = CNT_DEC;
                            c.res_set    = 1'b1;
                            c.res_status = ST_OK;
                            n_state      = S_RESP;
                        end else begin
                            c.ptr_op = PTR_LOAD_DN;
                            n_state  = S_SHIFT_DN;
                        end
                    end
                    CMD_FIND: begin
                        if (i_sts.cnt_zero) begin
                            c.res_set    = 1'b1;
                            c.res_status = ST_NOTFOUND;
                            n_state      = S_RESP;
                        end else begin
                            c.ptr_op = PTR_ZERO;
                            n_state  = S_SCAN;
                        end
                    end
                    CMD_MODIFY: begin
                        c.res_set = 1'b1;
                        n_state   = S_RESP;
                        if (i_sts.pos_gt || i_sts.pos_eq) begin
                            c.res_status = ST_RANGE;
                        end else begin
                            c.wb_op      = WB_VAL;
                            c.res_status = ST_OK;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                c.rd     = 1'b1;
                c.wb_op  = WB_UP;
                c.ptr_op = PTR_DEC;
                if (i_sts.ptr_at_pos) begin
                    n_state = S_UP_TAIL;
                end
            end
            S_UP_TAIL: begin
                c.wb_op = WB_UP;
                n_state = S_WR_VAL;
            end
            S_WR_VAL: begin
                c.wb_op      = WB_VAL;
                c.cnt_op     = CNT_INC;
                c.res_set    = 1'b1;
                c.res_status = ST_OK;
                n_state      = S_RESP;
            end
            S_SHIFT_DN: begin
                c.rd     = 1'b1;
                c.wb_op  = WB_DN;
                c.ptr_op = PTR_INC;
                if (i_sts.ptr_at_last) begin
                    n_state = S_DN_TAIL;
                end
            end
            S_DN_TAIL: begin
                c.wb_op      = WB_DN;
                c.cnt_op     = CNT_DEC;
                c.res_set    = 1'b1;
                c.res_status = ST_OK;
                n_state      = S_RESP;
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    c.res_set      = 1'b1;
                    c.res_status   = ST_OK;
                    c.res_idx_prev = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    c.rd     = 1'b1;
                    c.ptr_op = PTR_INC;
                    if (i_sts.ptr_at_last) begin
                        n_state = S_SCAN_TAIL;
                    end
                end
            end
            S_SCAN_TAIL: begin
                c.res_set = 1'b1;
                n_state   = S_RESP;
                if (i_sts.hit) begin
                    c.res_status   = ST_OK;
                    c.res_idx_prev = 1'b1;
                end else begin
                    c.res_status = ST_NOTFOUND;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    c.emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/sle_dp.sv]
module sle_dp
    import sle_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_cmd                   r_cmd;
    logic [PW-1:0]          r_pos;
    logic [VAL_W-1:0]       r_val;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_ptr;
    logic [AW-1:0]          r_prev;
    logic                   r_rd_vld;
    t_status                r_res_status;
    logic [IDX_W-1:0]       r_res_idx;
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    logic [CW-1:0]          cnt_m1;
    logic [PW-1:0]          cnt_ext;
    logic [VAL_W-1:0]       rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VAL_W-1:0]       wr_data;
    logic                   out_free;
    logic [OUT_TDATA_W-1:0] res_word;

    assign cnt_m1   = r_count - CW'(1);
    assign cnt_ext  = PW'(r_count);
    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.pos_gt      = r_pos > cnt_ext;
        o_sts.pos_eq      = r_pos == cnt_ext;
        o_sts.pos_last    = (r_pos + PW'(1)) == cnt_ext;
        o_sts.full        = r_count == CW'(CAPACITY);
        o_sts.cnt_zero    = r_count == '0;
        o_sts.ptr_at_pos  = PW'(r_ptr) == r_pos;
        o_sts.ptr_at_last = r_ptr == cnt_m1;
        o_sts.hit         = r_rd_vld && (rd_data == r_val);
        o_sts.out_free    = out_free;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pos[AW-1:0];
        wr_data = r_val;
        case (i_cmd.wb_op)
            WB_UP: begin
                wr_en   = r_rd_vld;
                wr_addr = r_prev + AW'(1);
                wr_data = rd_data;
            end
            WB_DN: begin
                wr_en   = r_rd_vld;
                wr_addr = r_prev - AW'(1);
                wr_data = rd_data;
            end
            WB_VAL: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        res_word                             = '0;
        res_word[OUT_STATUS_LSB +: STATUS_W] = r_res_status;
        res_word[OUT_IDX_LSB +: IDX_W]       = r_res_idx;
        res_word[OUT_COUNT_LSB +: COUNT_W]   = COUNT_W'(r_count);
    end

    sle_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_ptr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= t_cmd'(i_s_tdata[IN_CMD_LSB +: CMD_W]);
            r_pos <= PW'(i_s_tdata[IN_POS_LSB +: POS_W]);
            r_val <= i_s_tdata[IN_VAL_LSB +: VAL_W];
        end
        case (i_cmd.ptr_op)
            PTR_LOAD_UP: r_ptr <= cnt_m1;
            PTR_LOAD_DN: r_ptr <= CW'(r_pos) + CW'(1);
            PTR_ZERO:    r_ptr <= '0;
            PTR_INC:     r_ptr <= r_ptr + CW'(1);
            PTR_DEC:     r_ptr <= r_ptr - CW'(1);
            default:     r_ptr <= r_ptr;
        endcase
        if (i_cmd.rd) begin
            r_prev <= r_ptr[AW-1:0];
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_idx    <= i_cmd.res_idx_prev ? IDX_W'(r_prev) : '0;
        end
        if (i_cmd.emit) begin
            r_m_data <= res_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            case (i_cmd.cnt_op)
                CNT_INC: r_count <= r_count + CW'(1);
                CNT_DEC: r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

[hdl/sequential_list_engine_core.sv]
// ordered list engine: a list of signed 32-bit words kept in one ram of
// CAPACITY entries, plus a live count
// slave channel: one request word per handshake (command, position, value);
// master channel: exactly one result word per request (status, index, count)
// requests are taken one at a time; s_tready is high only while the engine
// waits for a request, and a new request may enter while the previous
// result still sits unclaimed in the output register
// error cases, modify, erase of the last entry and find on an empty list
// are answered straight from dispatch; insert at the end only writes the
// value; other inserts and erases first shift the entries past the
// position up or down by one; find scans from index 0 to a match or the end
// the engine returns to idle as its result is loaded and takes the next
// request from there; the list ram has a single write port: each shifted
// entry costs one ram read and one ram write, each searched entry one read
// reset (synchronous, active low) empties the list and drops any pending
// result; ram contents are not cleared
// a stalled master side holds the result; the engine still takes the next
// request, then waits in its response state until the result can move
module sequential_list_engine_core
    import sle_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // command [1:0], position [10:2], value [42:11], zero fill [47:43]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status [1:0], found_index [9:2], count [18:10], zero fill [23:19]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    sle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

[hdl/sle_chk.sv]
module sle_chk
    import sle_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic [STATUS_W-1:0] out_status;
    logic [IDX_W-1:0]    out_idx;
    logic [COUNT_W-1:0]  out_count;

    assign out_status = o_m_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign out_idx    = o_m_tdata[OUT_IDX_LSB +: IDX_W];
    assign out_count  = o_m_tdata[OUT_COUNT_LSB +: COUNT_W];

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (out_status == ST_FULL) |-> out_count == COUNT_W'(CAPACITY))
        else $error("full status with list not at capacity");

    a_index_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (out_idx != '0) |-> out_status == ST_OK)
        else $error("nonzero index on a failed request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (CAPACITY > 511) || (int'(out_count) <= CAPACITY))
        else $error("count beyond capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready still high after a request word");

endmodule

bind sequential_list_engine_core sle_chk #(
    .CAPACITY (CAPACITY)
) u_sle_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
